// ===== rtl/rdfr_pkg.sv =====
// Shared constants, register indexes and unit request/response types for the
// Rabin four-root decryption block. No dependencies.
`default_nettype none
package rdfr_pkg;
  localparam int PRIME_BITS = 16;
  localparam int PW = PRIME_BITS;
  localparam int NW = 2 * PW;
  localparam int SW = PW + 3;
  localparam int EW = PW - 1;
  localparam int CT_W = 32;
  localparam int OUT_W = 32;
  localparam int REG_W = 16;
  localparam int CFG_IW = 1;

  localparam logic [CFG_IW-1:0] REG_PRIME_P = 1'b0;
  localparam logic [CFG_IW-1:0] REG_PRIME_Q = 1'b1;

  localparam logic [PW-1:0] RESET_P = PW'(7);
  localparam logic [PW-1:0] RESET_Q = PW'(11);

  typedef struct packed {
    logic start;
    logic [NW-1:0] a;
    logic [NW-1:0] b;
    logic [NW-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic done;
    logic [NW-1:0] res;
  } mm_rsp_t;

  typedef struct packed {
    logic start;
    logic [CT_W-1:0] dividend;
    logic [PW-1:0] divisor;
    logic signed [SW-1:0] ms;
    logic signed [SW-1:0] mt;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [PW-1:0] rem;
    logic signed [SW-1:0] acc_s;
    logic signed [SW-1:0] acc_t;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/rdfr_mulmod.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, add and double
// with a conditional subtract of the modulus. Depends on rdfr_pkg.
`default_nettype none
module rdfr_mulmod (
  input  wire logic clk,
  input  wire logic rst,
  input  rdfr_pkg::mm_req_t req,
  output rdfr_pkg::mm_rsp_t rsp
);
  import rdfr_pkg::*;

  logic busy;
  logic done;
  logic [NW-1:0] a;
  logic [NW-1:0] b;
  logic [NW-1:0] m;
  logic [NW-1:0] acc;
  logic [NW:0] sum;
  logic [NW:0] dbl;

  always_comb begin
    sum = {1'b0, acc} + {1'b0, a};
    dbl = {1'b0, a} + {1'b0, a};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && b == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
      m <= req.m;
      acc <= '0;
    end else if (busy && b != '0) begin
      if (b[0]) begin
        acc <= (sum >= {1'b0, m}) ? NW'(sum - {1'b0, m}) : NW'(sum);
      end
      a <= (dbl >= {1'b0, m}) ? NW'(dbl - {1'b0, m}) : NW'(dbl);
      b <= b >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.res = acc;
endmodule
`default_nettype wire

// ===== rtl/rdfr_div.sv =====
// Bit-serial restoring divider that also accumulates quotient times two
// signed factors, one quotient bit per cycle. Depends on rdfr_pkg.
`default_nettype none
module rdfr_div (
  input  wire logic clk,
  input  wire logic rst,
  input  rdfr_pkg::div_req_t req,
  output rdfr_pkg::div_rsp_t rsp
);
  import rdfr_pkg::*;

  localparam int CW = $clog2(CT_W + 1);

  logic busy;
  logic done;
  logic [CW-1:0] cnt;
  logic [CT_W-1:0] dvd;
  logic [PW-1:0] dvs;
  logic [PW-1:0] rem;
  logic signed [SW-1:0] ms;
  logic signed [SW-1:0] mt;
  logic signed [SW-1:0] acc_s;
  logic signed [SW-1:0] acc_t;
  logic [PW:0] rem2;
  logic ge;

  always_comb begin
    rem2 = {rem, dvd[CT_W-1]};
    ge = rem2 >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= CW'(CT_W);
      dvd <= req.dividend;
      dvs <= req.divisor;
      ms <= req.ms;
      mt <= req.mt;
      rem <= '0;
      acc_s <= '0;
      acc_t <= '0;
    end else if (busy && cnt != '0) begin
      cnt <= cnt - 1'b1;
      dvd <= dvd << 1;
      rem <= ge ? PW'(rem2 - {1'b0, dvs}) : PW'(rem2);
      acc_s <= (acc_s <<< 1) + (ge ? ms : SW'(0));
      acc_t <= (acc_t <<< 1) + (ge ? mt : SW'(0));
    end
  end

  assign rsp.done = done;
  assign rsp.rem = rem;
  assign rsp.acc_s = acc_s;
  assign rsp.acc_t = acc_t;
endmodule
`default_nettype wire

// ===== rtl/rabin_decrypt_four_roots_top.sv =====
// Top level of the Rabin four-root decryption block: sequencer, prime
// registers and output register. Depends on rdfr_pkg, rdfr_mulmod, rdfr_div.
//
// Usage: write prime_p (index 0) and prime_q (index 1) on the configuration
// channel while the block is idle; cfg_ready is always high. Each input beat
// carries one ciphertext, and each output beat returns its four roots mod p*q.
// The block handles one item at a time. An item first reduces the ciphertext
// mod p and mod q on the serial divider, then runs two square-and-multiply
// exponentiations on the serial modular multiplier (up to about 2*PRIME_BITS
// multiplications each), then extended Euclid on the divider, one division per
// quotient step, then four CRT multiplications on the multiplier. A product
// p*q of zero skips this arithmetic and gives zero roots.
// The result sits in an output register, so a new input beat is accepted while
// the receiver stalls; a finished item then waits until that register is free.
// Reset empties the output register, returns the sequencer to idle and loads
// prime_p = 7 and prime_q = 11.
`default_nettype none
module rabin_decrypt_four_roots_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [rdfr_pkg::CT_W-1:0] ciphertext,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [rdfr_pkg::OUT_W-1:0] root_one,
  output logic [rdfr_pkg::OUT_W-1:0] root_two,
  output logic [rdfr_pkg::OUT_W-1:0] root_three,
  output logic [rdfr_pkg::OUT_W-1:0] root_four,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [rdfr_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [rdfr_pkg::REG_W-1:0] cfg_data
);
  import rdfr_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RDP = 4'd1;
  localparam logic [3:0] ST_RDQ = 4'd2;
  localparam logic [3:0] ST_PCHK = 4'd3;
  localparam logic [3:0] ST_PM1 = 4'd4;
  localparam logic [3:0] ST_PM2 = 4'd5;
  localparam logic [3:0] ST_EUC = 4'd6;
  localparam logic [3:0] ST_EDIV = 4'd7;
  localparam logic [3:0] ST_FIX = 4'd8;
  localparam logic [3:0] ST_T1A = 4'd9;
  localparam logic [3:0] ST_T1B = 4'd10;
  localparam logic [3:0] ST_T2A = 4'd11;
  localparam logic [3:0] ST_T2B = 4'd12;
  localparam logic [3:0] ST_FIN = 4'd13;

  logic [3:0] state;
  logic [PW-1:0] prime_p;
  logic [PW-1:0] prime_q;
  logic [NW-1:0] n;
  logic [NW-1:0] n_next;
  logic [PW-1:0] cr;
  logic [PW-1:0] cs;
  logic sel;
  logic [NW-1:0] pacc;
  logic [NW-1:0] base;
  logic [NW-1:0] modm;
  logic [EW-1:0] expo;
  logic [PW-1:0] r_res;
  logic [PW-1:0] s_res;
  logic [PW-1:0] r0;
  logic [PW-1:0] r1;
  logic signed [SW-1:0] s0;
  logic signed [SW-1:0] s1;
  logic signed [SW-1:0] t0;
  logic signed [SW-1:0] t1c;
  logic [NW-1:0] cm;
  logic [NW-1:0] dm_next;
  logic [NW-1:0] cm_next;
  logic [NW-1:0] pn;
  logic [NW-1:0] qn;
  logic [NW-1:0] t1;
  logic [NW-1:0] t2;
  logic [NW:0] rsum;
  logic [NW-1:0] root1;
  logic [NW-1:0] root3;
  logic [NW-1:0] root2;
  logic [NW-1:0] root4;
  logic out_load;
  mm_req_t mm_req;
  mm_rsp_t mm_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic [NW-1:0] smod(logic signed [SW-1:0] v, logic [NW-1:0] m);
    logic signed [NW+1:0] x;
    logic signed [NW+1:0] mx;
    x = (NW+2)'(v);
    mx = signed'({2'b00, m});
    if (x < 0) begin
      x = x + mx;
    end else if (x >= mx) begin
      x = x - mx;
    end
    return x[NW-1:0];
  endfunction

  function automatic logic [EW-1:0] half_exp(logic [PW-1:0] v);
    logic [PW:0] w;
    w = {1'b0, v} + 1'b1;
    return w[PW:2];
  endfunction

  rdfr_mulmod u_mulmod (.clk(clk), .rst(rst), .req(mm_req), .rsp(mm_rsp));
  rdfr_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    n_next = NW'(prime_p) * NW'(prime_q);
    cm_next = smod(s0, n);
    dm_next = smod(t0, n);
    pn = (NW'(prime_p) >= n) ? '0 : NW'(prime_p);
    qn = (NW'(prime_q) >= n) ? '0 : NW'(prime_q);
    rsum = {1'b0, t1} + {1'b0, t2};
    root1 = (rsum >= {1'b0, n}) ? NW'(rsum - {1'b0, n}) : NW'(rsum);
    root3 = (t1 >= t2) ? (t1 - t2) : NW'({1'b0, t1} + {1'b0, n} - {1'b0, t2});
    root2 = (root1 == '0) ? '0 : n - root1;
    root4 = (root3 == '0) ? '0 : n - root3;
    out_load = (state == ST_FIN) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_p <= RESET_P;
      prime_q <= RESET_Q;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRIME_P: prime_p <= PW'(cfg_data);
        REG_PRIME_Q: prime_q <= PW'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      mm_req.start <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      mm_req.start <= 1'b0;
      div_req.start <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (n_next == '0) begin
              state <= ST_FIN;
            end else begin
              div_req.start <= 1'b1;
              state <= ST_RDP;
            end
          end
        end
        ST_RDP: begin
          if (div_rsp.done) begin
            div_req.start <= 1'b1;
            state <= ST_RDQ;
          end
        end
        ST_RDQ: begin
          if (div_rsp.done) begin
            state <= ST_PCHK;
          end
        end
        ST_PCHK: begin
          if (expo == '0) begin
            if (sel) begin
              state <= ST_EUC;
            end
          end else begin
            mm_req.start <= 1'b1;
            state <= expo[0] ? ST_PM1 : ST_PM2;
          end
        end
        ST_PM1: begin
          if (mm_rsp.done) begin
            mm_req.start <= 1'b1;
            state <= ST_PM2;
          end
        end
        ST_PM2: begin
          if (mm_rsp.done) begin
            state <= ST_PCHK;
          end
        end
        ST_EUC: begin
          if (r1 == '0) begin
            state <= ST_FIX;
          end else begin
            div_req.start <= 1'b1;
            state <= ST_EDIV;
          end
        end
        ST_EDIV: begin
          if (div_rsp.done) begin
            state <= ST_EUC;
          end
        end
        ST_FIX: begin
          mm_req.start <= 1'b1;
          state <= ST_T1A;
        end
        ST_T1A: begin
          if (mm_rsp.done) begin
            mm_req.start <= 1'b1;
            state <= ST_T1B;
          end
        end
        ST_T1B: begin
          if (mm_rsp.done) begin
            mm_req.start <= 1'b1;
            state <= ST_T2A;
          end
        end
        ST_T2A: begin
          if (mm_rsp.done) begin
            mm_req.start <= 1'b1;
            state <= ST_T2B;
          end
        end
        ST_T2B: begin
          if (mm_rsp.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        n <= n_next;
        t1 <= '0;
        t2 <= '0;
        div_req.dividend <= ciphertext;
        div_req.divisor <= prime_p;
        div_req.ms <= '0;
        div_req.mt <= '0;
      end
      ST_RDP: begin
        cr <= div_rsp.rem;
        div_req.divisor <= prime_q;
      end
      ST_RDQ: begin
        cs <= div_rsp.rem;
        sel <= 1'b0;
        pacc <= (prime_p == PW'(1)) ? '0 : NW'(1);
        base <= NW'(cr);
        modm <= NW'(prime_p);
        expo <= half_exp(prime_p);
      end
      ST_PCHK: begin
        if (expo == '0) begin
          if (!sel) begin
            r_res <= PW'(pacc);
            sel <= 1'b1;
            pacc <= (prime_q == PW'(1)) ? '0 : NW'(1);
            base <= NW'(cs);
            modm <= NW'(prime_q);
            expo <= half_exp(prime_q);
          end else begin
            s_res <= PW'(pacc);
            r0 <= prime_p;
            r1 <= prime_q;
            s0 <= SW'(1);
            s1 <= '0;
            t0 <= '0;
            t1c <= SW'(1);
          end
        end else begin
          mm_req.a <= expo[0] ? pacc : base;
          mm_req.b <= base;
          mm_req.m <= modm;
        end
      end
      ST_PM1: begin
        if (mm_rsp.done) begin
          pacc <= mm_rsp.res;
          mm_req.a <= base;
          mm_req.b <= base;
        end
      end
      ST_PM2: begin
        if (mm_rsp.done) begin
          base <= mm_rsp.res;
          expo <= expo >> 1;
        end
      end
      ST_EUC: begin
        div_req.dividend <= CT_W'(r0);
        div_req.divisor <= r1;
        div_req.ms <= s1;
        div_req.mt <= t1c;
      end
      ST_EDIV: begin
        if (div_rsp.done) begin
          r0 <= r1;
          r1 <= div_rsp.rem;
          s0 <= s1;
          s1 <= s0 - div_rsp.acc_s;
          t0 <= t1c;
          t1c <= t0 - div_rsp.acc_t;
        end
      end
      ST_FIX: begin
        cm <= cm_next;
        mm_req.a <= NW'(r_res);
        mm_req.b <= dm_next;
        mm_req.m <= n;
      end
      ST_T1A: begin
        if (mm_rsp.done) begin
          mm_req.a <= mm_rsp.res;
          mm_req.b <= qn;
        end
      end
      ST_T1B: begin
        if (mm_rsp.done) begin
          t1 <= mm_rsp.res;
          mm_req.a <= NW'(s_res);
          mm_req.b <= cm;
        end
      end
      ST_T2A: begin
        if (mm_rsp.done) begin
          mm_req.a <= mm_rsp.res;
          mm_req.b <= pn;
        end
      end
      ST_T2B: begin
        if (mm_rsp.done) begin
          t2 <= mm_rsp.res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      root_one <= OUT_W'(root1);
      root_two <= OUT_W'(root2);
      root_three <= OUT_W'(root3);
      root_four <= OUT_W'(root4);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rdfr_checker.sv =====
// Port-level checks for the Rabin four-root decryption block, bound to the
// top level. Depends only on the top level's ports.
`default_nettype none
module rdfr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] root_one,
  input wire logic [31:0] root_two,
  input wire logic [31:0] root_three,
  input wire logic [31:0] root_four
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_one) && $stable(root_three))
    else $error("stalled output beat changed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_zero_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (root_one != 32'd0 || root_two == 32'd0) &&
                  (root_three != 32'd0 || root_four == 32'd0))
    else $error("negated root of a zero root is not zero");
endmodule

bind rabin_decrypt_four_roots_top rdfr_checker u_rdfr_checker (.*);
`default_nettype wire
